### sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge while the reset is released.
`define HM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Property checked at every rising edge, reset included.
`define HM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### sv/hmntf_pkg.sv
// Shared types and constants of the heightmap tangent frame block.
`timescale 1ns / 1ps
`default_nettype none

package hmntf_pkg;

    localparam int VEC_W      = 48;
    localparam int UNIT_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_DATA_W = 160;

    // Wide signed vector component fed to the unit-vector engine.
    typedef logic signed [VEC_W-1:0] comp_t;
    // Unit vector component, signed Q1.14.
    typedef logic signed [UNIT_W-1:0] unit_t;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_DEPTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_SPACING = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SCALE = 2'd3;

endpackage

`default_nettype wire

### sv/heightmap_normal_tangent_frame_top.sv
// Top level of the heightmap vertex height and tangent frame generator.
// Usage:
//   Height samples enter on the s_axis channel in raster order, one item per
//   vertex; tuser high marks a drain item that flushes one vertex of the last
//   row. Row 0 gives no result; a sample in row r gives vertex (r-1, c); after
//   the last row, each drain item gives one vertex of that row.
//   Results leave on m_axis: tdata packs the height and the normal, tangent and
//   binormal in Q1.14; tlast marks the final vertex of the grid. Registers are
//   to be written on the cfg channel only while idle; the block does not check.
// Operation:
//   An item that gives a result makes four passes through the shared
//   unit-vector engine, each with a square root and a divider. An item that
//   gives no result only reads the row buffers and writes back; an ignored
//   item is dropped. The row buffers are two RAMs with a registered read;
//   one item is worked on at a time, so no forwarding is needed.
// Reset and stalls:
//   Reset clears the counters and loads the register defaults; row buffer
//   contents stay unknown until written. A finished result waits in the output
//   register while the next item is accepted and worked on; input is held off
//   while an item is worked on, and a second result waits until the first goes.
`timescale 1ns / 1ps
`default_nettype none

module heightmap_normal_tangent_frame_top
    import hmntf_pkg::*;
#(
    parameter int MAX_GRID_WIDTH = 256
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [15:0]           s_axis_tdata,   // height_sample
    input  wire logic                  s_axis_tuser,   // drain
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // vertex_height, normal_x/y/z, tangent_x/y/z, binormal_x/y/z, 16 bits each
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tlast,   // last_vertex
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [15:0]           cfg_data
);

    localparam int AW = $clog2(MAX_GRID_WIDTH);
    localparam logic [31:0]   MAX_W32  = 32'(MAX_GRID_WIDTH);
    localparam logic [AW-1:0] IDX_LAST = AW'(MAX_GRID_WIDTH - 1);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_RD1  = 5'd1;
    localparam logic [4:0] ST_RD2  = 5'd2;
    localparam logic [4:0] ST_VN   = 5'd3;
    localparam logic [4:0] ST_WN   = 5'd4;
    localparam logic [4:0] ST_WT0  = 5'd5;
    localparam logic [4:0] ST_DOT  = 5'd6;
    localparam logic [4:0] ST_DSUM = 5'd7;
    localparam logic [4:0] ST_GS   = 5'd8;
    localparam logic [4:0] ST_GSS  = 5'd9;
    localparam logic [4:0] ST_WT   = 5'd10;
    localparam logic [4:0] ST_CR   = 5'd11;
    localparam logic [4:0] ST_CRS  = 5'd12;
    localparam logic [4:0] ST_WB   = 5'd13;
    localparam logic [4:0] ST_OUT  = 5'd14;

    // Control state.
    logic [4:0]  state_reg, state_next;
    logic [8:0]  col_reg, col_next;
    logic [8:0]  row_reg, row_next;
    logic [15:0] left_h_reg, left_h_next;
    logic        m_valid_reg, m_valid_next;
    logic        unz_start_reg, unz_start_next;

    // Configuration registers.
    logic [8:0]  gw_reg, gd_reg;
    logic [15:0] gs_reg, hs_reg;

    // Item and datapath registers.
    logic          fill_reg, edge_reg, first_reg, last_reg, emit_reg;
    logic [AW-1:0] idx_reg;
    logic [15:0]   h_reg, center_reg, older_reg, vh_reg;
    logic [16:0]   dx_reg, dz_reg;
    logic signed [16:0] dhx_reg, dhz_reg;
    logic          lastv_reg;
    comp_t         vin_reg [3];
    unit_t         n_reg [3];
    unit_t         t0_reg [3];
    unit_t         t_reg [3];
    logic signed [31:0] dp_reg [3];
    logic signed [33:0] d_reg;
    comp_t         gp_reg [3];
    logic signed [31:0] cp_reg [6];
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic          m_last_reg;

    // Accept-time decode.
    logic          in_fire, take, fill_cur, first_cur, last_cur;
    logic [31:0]   col32, gw32, w_lo, w_eff;
    logic [8:0]    dep_eff;
    logic [AW-1:0] idx_cur;
    logic [31:0]   hprod;

    // Row buffer ports.
    logic          nw_rd_en, ol_rd_en, wr_en;
    logic [AW-1:0] nw_rd_addr;
    logic [15:0]   nw_rd_data, ol_rd_data;

    // Geometry at read-back.
    logic [15:0]   left_v, right_v, bottom_v, top_v;
    logic          kx2, kz2;

    // Products.
    logic signed [17:0] dx_s, dz_s, ndhx, ndhz;
    logic signed [35:0] vn_p [3];
    logic signed [31:0] dot_p [3];
    logic signed [49:0] gs_p [3];
    logic signed [31:0] cr_p [6];

    unit_t unz_vout [3];
    logic  unz_done;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign col32     = 32'(col_reg);
    assign gw32      = 32'(gw_reg);
    assign w_lo      = (gw32 < 32'd2) ? 32'd2 : gw32;
    assign w_eff     = (w_lo > MAX_W32) ? MAX_W32 : w_lo;
    assign dep_eff   = (gd_reg < 9'd2) ? 9'd2 : gd_reg;
    assign fill_cur  = (row_reg < dep_eff);
    assign first_cur = (col_reg == 9'd0);
    assign last_cur  = (col32 >= w_eff - 32'd1);
    assign idx_cur   = (col32 < MAX_W32) ? col32[AW-1:0] : IDX_LAST;
    // A drain before the last row and a sample while draining are dropped.
    assign take      = fill_cur ? !s_axis_tuser : s_axis_tuser;
    assign hprod     = 32'(s_axis_tdata) * 32'(hs_reg);

    assign nw_rd_en   = (in_fire && take) || (state_reg == ST_RD1);
    assign nw_rd_addr = (state_reg == ST_IDLE) ? idx_cur : idx_reg + AW'(1);
    assign ol_rd_en   = in_fire && take;
    assign wr_en      = (state_reg == ST_RD2) && fill_reg;

    hmntf_ram #(
        .WIDTH (16),
        .DEPTH (MAX_GRID_WIDTH)
    ) u_newer_row (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (h_reg),
        .rd_en   (nw_rd_en),
        .rd_addr (nw_rd_addr),
        .rd_data (nw_rd_data)
    );

    hmntf_ram #(
        .WIDTH (16),
        .DEPTH (MAX_GRID_WIDTH)
    ) u_older_row (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (center_reg),
        .rd_en   (ol_rd_en),
        .rd_addr (idx_cur),
        .rd_data (ol_rd_data)
    );

    hmntf_unitize u_unitize (
        .clk   (clk),
        .rst_n (rst_n),
        .start (unz_start_reg),
        .vin   (vin_reg),
        .vout  (unz_vout),
        .done  (unz_done)
    );

    // Edge clamping: the missing neighbor is the center and the distance
    // shrinks to one spacing. While draining the top neighbor is the center.
    assign left_v   = first_reg ? center_reg : left_h_reg;
    assign right_v  = last_reg ? center_reg : nw_rd_data;
    assign bottom_v = (fill_reg && edge_reg) ? center_reg : older_reg;
    assign top_v    = fill_reg ? h_reg : center_reg;
    assign kx2      = !(first_reg || last_reg);
    assign kz2      = fill_reg && !edge_reg;

    assign dx_s = {1'b0, dx_reg};
    assign dz_s = {1'b0, dz_reg};
    assign ndhx = -{dhx_reg[16], dhx_reg};
    assign ndhz = -{dhz_reg[16], dhz_reg};

    always_comb
    begin
        vn_p[0] = dz_s * ndhx;
        vn_p[1] = dz_s * dx_s;
        vn_p[2] = ndhz * dx_s;
        for (int i = 0; i < 3; i++)
        begin
            dot_p[i] = n_reg[i] * t0_reg[i];
            gs_p[i]  = n_reg[i] * d_reg;
        end
        cr_p[0] = n_reg[1] * t_reg[2];
        cr_p[1] = n_reg[2] * t_reg[1];
        cr_p[2] = n_reg[2] * t_reg[0];
        cr_p[3] = n_reg[0] * t_reg[2];
        cr_p[4] = n_reg[0] * t_reg[1];
        cr_p[5] = n_reg[1] * t_reg[0];
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        left_h_next    = left_h_reg;
        unz_start_next = 1'b0;
        m_valid_next   = m_valid_reg;
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && take)
                begin
                    state_next = ST_RD1;
                    if (last_cur)
                    begin
                        col_next = 9'd0;
                        row_next = fill_cur ? row_reg + 9'd1 : 9'd0;
                    end
                    else
                    begin
                        col_next = col_reg + 9'd1;
                    end
                end
            end
            ST_RD1: state_next = ST_RD2;
            ST_RD2:
            begin
                left_h_next = center_reg;
                state_next  = emit_reg ? ST_VN : ST_IDLE;
            end
            ST_VN:
            begin
                unz_start_next = 1'b1;
                state_next     = ST_WN;
            end
            ST_WN:
            begin
                if (unz_done)
                begin
                    unz_start_next = 1'b1;
                    state_next     = ST_WT0;
                end
            end
            ST_WT0:
            begin
                if (unz_done)
                begin
                    state_next = ST_DOT;
                end
            end
            ST_DOT:  state_next = ST_DSUM;
            ST_DSUM: state_next = ST_GS;
            ST_GS:   state_next = ST_GSS;
            ST_GSS:
            begin
                unz_start_next = 1'b1;
                state_next     = ST_WT;
            end
            ST_WT:
            begin
                if (unz_done)
                begin
                    state_next = ST_CR;
                end
            end
            ST_CR:   state_next = ST_CRS;
            ST_CRS:
            begin
                unz_start_next = 1'b1;
                state_next     = ST_WB;
            end
            ST_WB:
            begin
                if (unz_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= 9'd0;
            row_reg       <= 9'd0;
            left_h_reg    <= 16'd0;
            m_valid_reg   <= 1'b0;
            unz_start_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            left_h_reg    <= left_h_next;
            m_valid_reg   <= m_valid_next;
            unz_start_reg <= unz_start_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg <= 9'd256;
            gd_reg <= 9'd256;
            gs_reg <= 16'd256;
            hs_reg <= 16'd256;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:   gw_reg <= cfg_data[8:0];
                REG_GRID_DEPTH:   gd_reg <= cfg_data[8:0];
                REG_GRID_SPACING: gs_reg <= cfg_data;
                REG_HEIGHT_SCALE: hs_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers, loaded by the sequencer step that owns them.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    fill_reg  <= fill_cur;
                    edge_reg  <= (row_reg == 9'd1);
                    first_reg <= first_cur;
                    last_reg  <= last_cur;
                    emit_reg  <= !fill_cur || (row_reg != 9'd0);
                    idx_reg   <= idx_cur;
                    h_reg     <= hprod[31:16];
                end
            end
            ST_RD1:
            begin
                center_reg <= nw_rd_data;
                older_reg  <= ol_rd_data;
            end
            ST_RD2:
            begin
                dx_reg    <= kx2 ? {gs_reg, 1'b0} : {1'b0, gs_reg};
                dz_reg    <= kz2 ? {gs_reg, 1'b0} : {1'b0, gs_reg};
                dhx_reg   <= $signed({1'b0, right_v}) - $signed({1'b0, left_v});
                dhz_reg   <= $signed({1'b0, top_v}) - $signed({1'b0, bottom_v});
                vh_reg    <= center_reg;
                lastv_reg <= !fill_reg && last_reg;
            end
            ST_VN:
            begin
                // Cross product of the z slope and the x slope vectors.
                for (int i = 0; i < 3; i++)
                begin
                    vin_reg[i] <= comp_t'(vn_p[i]);
                end
            end
            ST_WN:
            begin
                if (unz_done)
                begin
                    n_reg      <= unz_vout;
                    vin_reg[0] <= comp_t'(dx_s);
                    vin_reg[1] <= comp_t'(dhx_reg);
                    vin_reg[2] <= '0;
                end
            end
            ST_WT0:
            begin
                if (unz_done)
                begin
                    t0_reg <= unz_vout;
                end
            end
            ST_DOT:
            begin
                dp_reg <= dot_p;
            end
            ST_DSUM:
            begin
                d_reg <= 34'(dp_reg[0]) + 34'(dp_reg[1]) + 34'(dp_reg[2]);
            end
            ST_GS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    gp_reg[i] <= gs_p[i][VEC_W-1:0];
                end
            end
            ST_GSS:
            begin
                // Remove the normal's share of the x slope.
                for (int i = 0; i < 3; i++)
                begin
                    vin_reg[i] <= (comp_t'(t0_reg[i]) <<< 28) - gp_reg[i];
                end
            end
            ST_WT:
            begin
                if (unz_done)
                begin
                    t_reg <= unz_vout;
                end
            end
            ST_CR:
            begin
                cp_reg <= cr_p;
            end
            ST_CRS:
            begin
                vin_reg[0] <= comp_t'(cp_reg[0]) - comp_t'(cp_reg[1]);
                vin_reg[1] <= comp_t'(cp_reg[2]) - comp_t'(cp_reg[3]);
                vin_reg[2] <= comp_t'(cp_reg[4]) - comp_t'(cp_reg[5]);
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_data_reg <= {unz_vout[2], unz_vout[1], unz_vout[0],
                                   t_reg[2], t_reg[1], t_reg[0],
                                   n_reg[2], n_reg[1], n_reg[0], vh_reg};
                    m_last_reg <= lastv_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

`default_nettype wire

### sv/hmntf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module hmntf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### sv/hmntf_unitize.sv
// Multi-cycle unit-vector engine: scale, square sum, square root and rounded division.
`timescale 1ns / 1ps
`default_nettype none

module hmntf_unitize
    import hmntf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire comp_t vin [3],
    output unit_t      vout [3],
    output logic       done
);

    localparam logic [2:0] U_IDLE = 3'd0;
    localparam logic [2:0] U_NORM = 3'd1;
    localparam logic [2:0] U_SQ   = 3'd2;
    localparam logic [2:0] U_SUM  = 3'd3;
    localparam logic [2:0] U_SQRT = 3'd4;
    localparam logic [2:0] U_DIVI = 3'd5;
    localparam logic [2:0] U_DIV  = 3'd6;
    localparam logic [2:0] U_OUT  = 3'd7;

    localparam logic [41:0] SQRT_TOP = 42'd1 << 40;

    logic [2:0]  state_reg, state_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [47:0] mag_reg [3];
    logic        neg_reg [3];
    logic [39:0] sq_reg [3];
    logic [39:0] sq_p [3];
    logic [41:0] rem_reg, root_reg, bit_reg;
    logic [41:0] trial;
    logic [35:0] num_reg [3];
    logic [35:0] dvs_reg;
    logic [14:0] q_reg [3];
    logic [47:0] m_max;
    logic        m_zero, m_in_range;

    always_comb
    begin
        m_max = mag_reg[0];
        if (mag_reg[1] > m_max)
        begin
            m_max = mag_reg[1];
        end
        if (mag_reg[2] > m_max)
        begin
            m_max = mag_reg[2];
        end
    end

    assign m_zero     = (m_max == 48'd0);
    assign m_in_range = (m_max[47:20] == 28'd0) && m_max[19];
    assign trial      = root_reg + bit_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_p[i] = 40'(mag_reg[i][19:0]) * 40'(mag_reg[i][19:0]);
            vout[i] = neg_reg[i] ? -unit_t'({1'b0, q_reg[i]}) : unit_t'({1'b0, q_reg[i]});
        end
    end

    assign done = (state_reg == U_OUT);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            U_IDLE:
            begin
                if (start)
                begin
                    state_next = U_NORM;
                end
            end
            U_NORM:
            begin
                if (m_zero)
                begin
                    state_next = U_OUT;
                end
                else if (m_in_range)
                begin
                    state_next = U_SQ;
                end
            end
            U_SQ:   state_next = U_SUM;
            U_SUM:  state_next = U_SQRT;
            U_SQRT:
            begin
                if (bit_reg == 42'd1)
                begin
                    state_next = U_DIVI;
                end
            end
            U_DIVI:
            begin
                cnt_next   = 4'd14;
                state_next = U_DIV;
            end
            U_DIV:
            begin
                if (cnt_reg == 4'd0)
                begin
                    state_next = U_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            U_OUT:  state_next = U_IDLE;
            default: state_next = U_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            cnt_reg   <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Datapath: the magnitudes are scaled until the largest lies in [2^19, 2^20),
    // then the length is found one result bit a cycle and all three quotients
    // are built in parallel, one bit a cycle.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            U_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        neg_reg[i] <= vin[i][VEC_W-1];
                        mag_reg[i] <= vin[i][VEC_W-1] ? 48'(-vin[i]) : 48'(vin[i]);
                    end
                end
            end
            U_NORM:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (m_zero)
                    begin
                        q_reg[i] <= 15'd0;
                    end
                    else if (m_max[47:28] != 20'd0)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 8;
                    end
                    else if (m_max[47:20] != 28'd0)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                    else if (m_max[19:11] == 9'd0)
                    begin
                        mag_reg[i] <= mag_reg[i] << 8;
                    end
                    else if (!m_max[19])
                    begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end
            end
            U_SQ:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sq_reg[i] <= sq_p[i];
                end
            end
            U_SUM:
            begin
                rem_reg  <= 42'(sq_reg[0]) + 42'(sq_reg[1]) + 42'(sq_reg[2]);
                root_reg <= 42'd0;
                bit_reg  <= SQRT_TOP;
            end
            U_SQRT:
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg  <= rem_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            U_DIVI:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    num_reg[i] <= 36'({mag_reg[i][19:0], 14'd0}) + 36'(root_reg[21:1]);
                    q_reg[i]   <= 15'd0;
                end
                dvs_reg <= {root_reg[21:0], 14'd0};
            end
            U_DIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (num_reg[i] >= dvs_reg)
                    begin
                        num_reg[i] <= num_reg[i] - dvs_reg;
                        q_reg[i]   <= {q_reg[i][13:0], 1'b1};
                    end
                    else
                    begin
                        q_reg[i] <= {q_reg[i][13:0], 1'b0};
                    end
                end
                dvs_reg <= dvs_reg >> 1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/hmntf_checker.sv
// Port-level checker for the heightmap tangent frame block, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hmntf_checker
    import hmntf_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic [15:0]           s_axis_tdata,
    input wire logic                  s_axis_tuser,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic                  m_axis_tlast,
    input wire logic                  cfg_valid,
    input wire logic                  cfg_ready,
    input wire logic [CFG_IDX_W-1:0]  cfg_index,
    input wire logic [15:0]           cfg_data
);

    logic in_seen;
    assign in_seen = s_axis_tvalid || s_axis_tuser || (s_axis_tdata != 16'd0)
                     || cfg_valid || cfg_ready || (cfg_index != REG_GRID_WIDTH)
                     || (cfg_data != 16'd0);

    `HM_ASSERT(a_out_valid_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result item dropped while stalled")
    `HM_ASSERT(a_out_data_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast), "result item changed while stalled")
    `HM_ASSERT(a_normal_range, clk, rst_n, m_axis_tvalid |-> $signed(m_axis_tdata[31:16]) <= 16384 && $signed(m_axis_tdata[31:16]) >= -16384 && $signed(m_axis_tdata[47:32]) <= 16384 && $signed(m_axis_tdata[47:32]) >= -16384 && $signed(m_axis_tdata[63:48]) <= 16384 && $signed(m_axis_tdata[63:48]) >= -16384, "normal component outside unit range")
    `HM_ASSERT(a_load_while_busy, clk, rst_n, $rose(m_axis_tvalid) |-> !$past(s_axis_tready), "result loaded while input side idle")
    `HM_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !m_axis_tvalid || in_seen, "result item valid during reset")

endmodule

bind heightmap_normal_tangent_frame_top hmntf_checker u_hmntf_checker (.*);

`default_nettype wire
